[rtl/erq_pkg.sv]
// ----------------------------------------------------------------------------
// erq_pkg: shared types and codes for the EDF ready queue
// Beat payloads, item kinds, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package erq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int TIME_W    = 63;
    localparam int SLOT_W    = 6;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] rel_deadline;
        logic [SLOT_W-1:0] slot;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   task_slot;
        logic [TIME_W-1:0]   task_start;
        logic [TIME_W-1:0]   task_duration;
        logic [TIME_W-1:0]   task_deadline;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_RD_ORD,
        ST_INS_RD_DL,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_DSP_RD_ORD,
        ST_DSP_RD_DAT,
        ST_DSP_CMP,
        ST_CPL_DATA,
        ST_CPL_RD_ORD,
        ST_CPL_CHK,
        ST_FINISH
    } state_t;

endpackage

[rtl/edf_ready_queue.sv]
// ----------------------------------------------------------------------------
// edf_ready_queue: earliest-deadline-first task table
// Insert, dispatch and complete beats over a deadline-ordered slot list.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall / item) carries one command beat:
//   insert a task, ask for the first ready task, or complete a slot. Every
//   item gives exactly one beat on the result channel (result_valid /
//   result_stall / result).
//   One item is worked on at a time; item_stall is low only while idle.
//   A single sequencer walks the order list held in RAM. Each entry takes
//   the states RD_ORD, RD_DL, CMP on insert, RD_ORD, RD_DAT, CMP on dispatch
//   and RD_ORD, CHK on complete. Insert waits longer in PLACE if the free-slot
//   scan (one valid bit a cycle, running alongside the walk) is still busy;
//   complete walks every entry of the list. After the result beat the
//   sequencer passes through idle again before it takes the next item.
//   The result register parts the two sides: a new item is taken while the
//   previous result still waits under result_stall; the sequencer only holds
//   in its last state if a second result is ready before the first is taken.
//   Reset empties the table at once (valid bits and count are cleared).
// ----------------------------------------------------------------------------
module edf_ready_queue #(
    parameter int DEPTH = erq_pkg::DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  erq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output erq_pkg::result_t result
);
    import erq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic             found_reg, found_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             result_valid_reg, result_valid_next;

    item_t             item_reg, item_next;
    logic [TIME_W-1:0] dl_reg, dl_next;
    result_t           res_reg, res_next;
    result_t           result_reg, result_next;

    // task storage and order list
    logic [TIME_W-1:0] start_mem [DEPTH];
    logic [TIME_W-1:0] dur_mem   [DEPTH];
    logic [TIME_W-1:0] dl_mem    [DEPTH];
    logic [IDX_W-1:0]  order_mem [DEPTH];

    logic [IDX_W-1:0]  ord_rd_reg;
    logic [TIME_W-1:0] start_rd_reg, dur_rd_reg, dl_rd_reg;

    logic              ord_re, ord_we, dat_re, dat_we;
    logic [IDX_W-1:0]  ord_raddr, ord_waddr, ord_wdata, dat_raddr, dat_waddr;

    logic [CNT_W-1:0]  idx_dec, idx_inc;
    logic [IDX_W-1:0]  idx_lo, idx_dec_lo;
    logic [31:0]       slot_ext, free_ext, ord_ext;
    logic [IDX_W-1:0]  slot_idx;
    logic              slot_ok, full, free_hit;
    logic [TIME_W:0]   dl_sum;
    logic [TIME_W-1:0] dl_sat;

    assign idx_dec    = idx_reg - CNT_W'(1);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_lo     = idx_reg[IDX_W-1:0];
    assign idx_dec_lo = idx_dec[IDX_W-1:0];
    assign slot_ext   = 32'(item_reg.slot);
    assign slot_idx   = slot_ext[IDX_W-1:0];
    assign free_ext   = 32'(free_reg);
    assign ord_ext    = 32'(ord_rd_reg);
    assign slot_ok    = (slot_ext < 32'(DEPTH)) && valid_reg[slot_idx];
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign free_hit   = !valid_reg[free_reg];

    // saturate the absolute deadline at the largest time
    assign dl_sum = {1'b0, item_reg.now} + {1'b0, item_reg.rel_deadline};
    assign dl_sat = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (item_reg.kind)
                    KIND_INSERT:
                    begin
                        if (full)
                            state_next = ST_FINISH;
                        else if (count_reg == '0)
                            state_next = ST_INS_PLACE;
                        else
                            state_next = ST_INS_RD_ORD;
                    end
                    KIND_DISPATCH:
                        state_next = (count_reg == '0) ? ST_FINISH : ST_DSP_RD_ORD;
                    KIND_COMPLETE:
                        state_next = slot_ok ? ST_CPL_DATA : ST_FINISH;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_INS_RD_ORD: state_next = ST_INS_RD_DL;
            ST_INS_RD_DL:  state_next = ST_INS_CMP;
            ST_INS_CMP:
            begin
                if ((dl_rd_reg > dl_reg) && (idx_reg != CNT_W'(1)))
                    state_next = ST_INS_RD_ORD;
                else
                    state_next = ST_INS_PLACE;
            end
            ST_INS_PLACE:
            begin
                if (free_hit)
                    state_next = ST_FINISH;
            end
            ST_DSP_RD_ORD: state_next = ST_DSP_RD_DAT;
            ST_DSP_RD_DAT: state_next = ST_DSP_CMP;
            ST_DSP_CMP:
            begin
                if ((start_rd_reg <= item_reg.now) || (idx_inc == count_reg))
                    state_next = ST_FINISH;
                else
                    state_next = ST_DSP_RD_ORD;
            end
            ST_CPL_DATA:   state_next = ST_CPL_RD_ORD;
            ST_CPL_RD_ORD: state_next = ST_CPL_CHK;
            ST_CPL_CHK:
                state_next = (idx_inc == count_reg) ? ST_FINISH : ST_CPL_RD_ORD;
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        count_next        = count_reg;
        idx_next          = idx_reg;
        free_next         = free_reg;
        found_next        = found_reg;
        valid_next        = valid_reg;
        item_next         = item_reg;
        dl_next           = dl_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        ord_re            = 1'b0;
        ord_we            = 1'b0;
        dat_re            = 1'b0;
        dat_we            = 1'b0;
        ord_raddr         = idx_lo;
        ord_waddr         = idx_lo;
        ord_wdata         = ord_rd_reg;
        dat_raddr         = ord_rd_reg;
        dat_waddr         = free_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    free_next  = '0;
                    found_next = 1'b0;
                end
            end
            ST_DECODE:
            begin
                dl_next   = dl_sat;
                idx_next  = (item_reg.kind == KIND_INSERT) ? count_reg : '0;
                dat_re    = 1'b1;
                dat_raddr = slot_idx;
                res_next  = '0;
                case (item_reg.kind)
                    KIND_INSERT:   res_next.status = full ? STATUS_FULL : STATUS_OK;
                    KIND_DISPATCH: res_next.status = STATUS_NOT_READY;
                    KIND_COMPLETE: res_next.status = STATUS_BAD_SLOT;
                    default:       res_next.status = STATUS_BAD_SLOT;
                endcase
            end
            ST_INS_RD_ORD:
            begin
                ord_re    = 1'b1;
                ord_raddr = idx_dec_lo;
                if (!free_hit)
                    free_next = free_reg + IDX_W'(1);
            end
            ST_INS_RD_DL:
            begin
                dat_re = 1'b1;
                if (!free_hit)
                    free_next = free_reg + IDX_W'(1);
            end
            ST_INS_CMP:
            begin
                // later deadlines move one place down the list
                if (dl_rd_reg > dl_reg)
                begin
                    ord_we   = 1'b1;
                    idx_next = idx_dec;
                end
                if (!free_hit)
                    free_next = free_reg + IDX_W'(1);
            end
            ST_INS_PLACE:
            begin
                if (free_hit)
                begin
                    ord_we                 = 1'b1;
                    ord_wdata              = free_reg;
                    dat_we                 = 1'b1;
                    valid_next[free_reg]   = 1'b1;
                    count_next             = count_reg + CNT_W'(1);
                    res_next.status        = STATUS_OK;
                    res_next.task_slot     = free_ext[SLOT_W-1:0];
                    res_next.task_start    = item_reg.start_time;
                    res_next.task_duration = item_reg.duration;
                    res_next.task_deadline = dl_reg;
                end
                else
                begin
                    free_next = free_reg + IDX_W'(1);
                end
            end
            ST_DSP_RD_ORD:
                ord_re = 1'b1;
            ST_DSP_RD_DAT:
                dat_re = 1'b1;
            ST_DSP_CMP:
            begin
                if (start_rd_reg <= item_reg.now)
                begin
                    res_next.status        = STATUS_OK;
                    res_next.task_slot     = ord_ext[SLOT_W-1:0];
                    res_next.task_start    = start_rd_reg;
                    res_next.task_duration = dur_rd_reg;
                    res_next.task_deadline = dl_rd_reg;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_CPL_DATA:
            begin
                res_next.status        = STATUS_OK;
                res_next.task_slot     = item_reg.slot;
                res_next.task_start    = start_rd_reg;
                res_next.task_duration = dur_rd_reg;
                res_next.task_deadline = dl_rd_reg;
                valid_next[slot_idx]   = 1'b0;
                idx_next               = '0;
            end
            ST_CPL_RD_ORD:
                ord_re = 1'b1;
            ST_CPL_CHK:
            begin
                // once the slot is seen, pull every later entry up by one
                if (found_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = idx_dec_lo;
                end
                if (ord_rd_reg == slot_idx)
                    found_next = 1'b1;
                if (idx_inc == count_reg)
                    count_next = count_reg - CNT_W'(1);
                else
                    idx_next = idx_inc;
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            free_reg         <= '0;
            found_reg        <= 1'b0;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            free_reg         <= free_next;
            found_reg        <= found_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        dl_reg     <= dl_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    // order list RAM
    always_ff @(posedge clk)
    begin
        if (ord_we)
            order_mem[ord_waddr] <= ord_wdata;
        if (ord_re)
            ord_rd_reg <= order_mem[ord_raddr];
    end

    // task data RAMs
    always_ff @(posedge clk)
    begin
        if (dat_we)
        begin
            start_mem[dat_waddr] <= item_reg.start_time;
            dur_mem[dat_waddr]   <= item_reg.duration;
            dl_mem[dat_waddr]    <= dl_reg;
        end
        if (dat_re)
        begin
            start_rd_reg <= start_mem[dat_raddr];
            dur_rd_reg   <= dur_mem[dat_raddr];
            dl_rd_reg    <= dl_mem[dat_raddr];
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == int'(count_reg)))
        else $error("valid bits disagree with entry count");

    a_place_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_PLACE) |-> (count_reg < CNT_W'(DEPTH)))
        else $error("placing a task into a full table");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted beat not decoded");

endmodule

[tb/sv/tb_edf_ready_queue.sv]
// ----------------------------------------------------------------------------
// tb_edf_ready_queue: self-checking bench for the EDF ready queue
// Drives insert, dispatch, complete and unused-kind beats: a directed opener,
// then random traffic under three idling patterns. A task-table tracker
// predicts every result beat and checks each one field by field.
// ----------------------------------------------------------------------------
module tb_edf_ready_queue;
    import erq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 250;
    localparam int TAIL_CYCLES = 250;
    localparam longint LIMIT_CYCLES = 2000000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int send_idle_pct;
    int recv_idle_pct;

    class ready_table_tracker;
        logic [TIME_W-1:0] slot_start [DEPTH];
        logic [TIME_W-1:0] slot_dur [DEPTH];
        logic [TIME_W-1:0] slot_dl [DEPTH];
        bit                slot_used [DEPTH];
        int unsigned       by_deadline [$];
        result_t           results_due [$];
        int                errors;

        function result_t slot_result(int unsigned s);
            result_t r;
            r.status        = STATUS_OK;
            r.task_slot     = SLOT_W'(s);
            r.task_start    = slot_start[s];
            r.task_duration = slot_dur[s];
            r.task_deadline = slot_dl[s];
            return r;
        endfunction

        function result_t predict(item_t it);
            result_t           r;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] dl;
            int unsigned       s;
            int unsigned       pos;
            r = '0;
            case (it.kind)
                KIND_INSERT:
                begin
                    if (by_deadline.size() >= DEPTH)
                    begin
                        r.status = STATUS_FULL;
                    end
                    else
                    begin
                        s = 0;
                        while (slot_used[s])
                            s++;
                        sum = {1'b0, it.rel_deadline} + {1'b0, it.now};
                        dl  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                        slot_start[s] = it.start_time;
                        slot_dur[s]   = it.duration;
                        slot_dl[s]    = dl;
                        slot_used[s]  = 1'b1;
                        // go behind every task whose deadline is not later
                        pos = 0;
                        while (pos < by_deadline.size() && slot_dl[by_deadline[pos]] <= dl)
                            pos++;
                        by_deadline.insert(pos, s);
                        r = slot_result(s);
                    end
                end
                KIND_DISPATCH:
                begin
                    r.status = STATUS_NOT_READY;
                    foreach (by_deadline[i])
                    begin
                        if (r.status != STATUS_OK && slot_start[by_deadline[i]] <= it.now)
                            r = slot_result(by_deadline[i]);
                    end
                end
                KIND_COMPLETE:
                begin
                    s = it.slot;
                    if (s >= DEPTH || !slot_used[s])
                    begin
                        r.status = STATUS_BAD_SLOT;
                    end
                    else
                    begin
                        r = slot_result(s);
                        slot_used[s] = 1'b0;
                        pos = 0;
                        while (by_deadline[pos] != s)
                            pos++;
                        by_deadline.delete(pos);
                    end
                end
                default:
                begin
                    r.status = STATUS_BAD_SLOT;
                end
            endcase
            return r;
        endfunction

        function void accept_item(item_t it);
            results_due.push_back(predict(it));
        endfunction

        function void compare_field(string field_name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, field_name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none due: expected nothing, got status %0d slot %0d",
                         $time, got.status, got.task_slot);
                return;
            end
            want = results_due.pop_front();
            compare_field("status", TIME_W'(want.status), TIME_W'(got.status));
            compare_field("task_slot", TIME_W'(want.task_slot), TIME_W'(got.task_slot));
            compare_field("task_start", want.task_start, got.task_start);
            compare_field("task_duration", want.task_duration, got.task_duration);
            compare_field("task_deadline", want.task_deadline, got.task_deadline);
        endfunction
    endclass

    ready_table_tracker tracker = new();

    edf_ready_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("FAIL edf_ready_queue");
        $finish;
    end

    // check result beats as they are taken, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_result(result);
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] t;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: t = TIME_W'($urandom_range(15));
            5:             t = '0;
            6:             t = TIME_MAX;
            7:             t = TIME_MAX - TIME_W'($urandom_range(15));
            default:       t = TIME_W'({$urandom, $urandom});
        endcase
        return t;
    endfunction

    function automatic item_t make_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                                        logic [TIME_W-1:0] start_time,
                                        logic [TIME_W-1:0] duration,
                                        logic [TIME_W-1:0] rel_deadline,
                                        logic [SLOT_W-1:0] slot);
        item_t it;
        it.kind         = kind;
        it.now          = now;
        it.start_time   = start_time;
        it.duration     = duration;
        it.rel_deadline = rel_deadline;
        it.slot         = slot;
        return it;
    endfunction

    // hold the beat until taken; valid stays high for a back-to-back follower
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        tracker.accept_item(it);
    endtask

    task automatic send_random(input bit draining);
        item_t it;
        int    r;
        int    insert_pct;
        int    complete_pct;
        insert_pct   = draining ? 15 : 50;
        complete_pct = draining ? 55 : 20;
        it = make_item(KIND_INSERT, pick_time(), pick_time(), pick_time(), pick_time(),
                       SLOT_W'($urandom));
        r = $urandom_range(99);
        if (r < insert_pct)
        begin
            it.kind = KIND_INSERT;
        end
        else if (r < insert_pct + 25)
        begin
            it.kind = KIND_DISPATCH;
        end
        else if (r < insert_pct + 25 + complete_pct)
        begin
            it.kind = KIND_COMPLETE;
            // mostly name a live slot, now and then a random one
            if (tracker.by_deadline.size() != 0 && $urandom_range(9) < 8)
                it.slot = SLOT_W'(tracker.by_deadline[
                              $urandom_range(tracker.by_deadline.size() - 1)]);
        end
        else
        begin
            it.kind = KIND_UNUSED;
        end
        send_item(it);
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        while (tracker.results_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        item          <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing ready, bad slot, unused kind
        send_item(make_item(KIND_DISPATCH, TIME_MAX, '0, '0, '0, '0));
        send_item(make_item(KIND_COMPLETE, '0, '0, '0, '0, '0));
        send_item(make_item(KIND_UNUSED, '0, '0, '0, '0, '0));
        // saturating deadline, then a zero deadline at the head
        send_item(make_item(KIND_INSERT, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, '1));
        send_item(make_item(KIND_INSERT, '0, '0, '0, '0, '0));
        // three equal deadlines, in insertion order
        send_item(make_item(KIND_INSERT, '0, 63'd5, 63'd3, 63'd10, '0));
        send_item(make_item(KIND_INSERT, '0, 63'd2, 63'd7, 63'd10, '0));
        send_item(make_item(KIND_INSERT, '0, '0, 63'd1, 63'd10, '0));
        send_item(make_item(KIND_DISPATCH, '0, '0, '0, '0, '0));
        send_item(make_item(KIND_COMPLETE, '0, '0, '0, '0, 6'd1));
        // first tasks in order not yet startable
        send_item(make_item(KIND_DISPATCH, 63'd1, '0, '0, '0, '0));
        send_item(make_item(KIND_DISPATCH, TIME_MAX, '0, '0, '0, '0));
        send_item(make_item(KIND_COMPLETE, '0, '0, '0, '0, 6'd63));
        send_item(make_item(KIND_COMPLETE, '0, '0, '0, '0, 6'd2));
        // refill the lowest free slot
        send_item(make_item(KIND_INSERT, TIME_MAX, 63'd4, 63'd4, 63'd1, '0));
        send_item(make_item(KIND_INSERT, '0, TIME_MAX, '0, TIME_MAX, '1));
        send_item(make_item(KIND_DISPATCH, 63'd3, '0, '0, '0, '0));
        send_item(make_item(KIND_COMPLETE, '0, '0, '0, '0, '0));
        send_item(make_item(KIND_COMPLETE, '0, '0, '0, '0, 6'd2));
        send_item(make_item(KIND_UNUSED, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, '1));
        send_item(make_item(KIND_DISPATCH, '0, '0, '0, '0, '0));
        hold_until_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 75;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                // fill the table, then push past full
                while (tracker.by_deadline.size() < DEPTH)
                    send_item(make_item(KIND_INSERT, pick_time(), pick_time(), pick_time(),
                                        pick_time(), SLOT_W'($urandom)));
                repeat (3)
                    send_item(make_item(KIND_INSERT, pick_time(), pick_time(), pick_time(),
                                        pick_time(), SLOT_W'($urandom)));
                send_item(make_item(KIND_DISPATCH, TIME_MAX, '0, '0, '0, '0));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(((n / 40) % 2) == 1);
            hold_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.results_due.size() == 0)
            $display("PASS edf_ready_queue");
        else
            $display("FAIL edf_ready_queue");
        $finish;
    end

endmodule
